// File: hdl/ptb_pkg.sv
`default_nettype none
package ptb_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int ELEMENT_BITS = 16;
    localparam int COORD_BITS   = 32;
    localparam int SLOT_BITS    = $clog2(MAX_POINTS);
    localparam int COUNT_BITS   = SLOT_BITS + 1;
    localparam int CMD_BITS     = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SLOT_BITS-1:0]         slot_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [ELEMENT_BITS-1:0]      elem_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD = 2'd0,
        CMD_TEST = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ
    } state_t;

    // control from the sequencer to the point store
    typedef struct packed {
        logic  load_en;
        slot_t load_idx;
        slot_t walk_idx;
        logic  query_en;
        slot_t query_idx;
        logic  claim_en;
        slot_t claim_idx;
    } store_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/ptb_store.sv
`default_nettype none
module ptb_store
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptb_pkg::store_ctrl_t  ctrl,
    input  wire ptb_pkg::point_t       load_point,
    input  wire ptb_pkg::elem_t        claim_elem,
    output ptb_pkg::point_t            walk_point,
    output ptb_pkg::elem_t             query_owner,
    output logic                       query_owned
);

    ptb_pkg::point_t coord_mem [ptb_pkg::MAX_POINTS];
    ptb_pkg::elem_t  owner_mem [ptb_pkg::MAX_POINTS];

    logic [ptb_pkg::MAX_POINTS-1:0] owned_reg;
    logic [ptb_pkg::MAX_POINTS-1:0] owned_next;
    ptb_pkg::point_t                walk_point_reg;
    ptb_pkg::elem_t                 query_owner_reg;
    logic                           query_owned_reg;
    logic                           claim_ok;

    // first box wins: an owned point is not claimed again until a load clears it
    assign claim_ok = ctrl.claim_en && !owned_reg[ctrl.claim_idx];

    always_comb
    begin
        owned_next = owned_reg;
        if (ctrl.load_en)
        begin
            owned_next[ctrl.load_idx] = 1'b0;
        end
        if (claim_ok)
        begin
            owned_next[ctrl.claim_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg <= '0;
        end
        else
        begin
            owned_reg <= owned_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            coord_mem[ctrl.load_idx] <= load_point;
        end
        walk_point_reg <= coord_mem[ctrl.walk_idx];
    end

    always_ff @(posedge clk)
    begin
        if (claim_ok)
        begin
            owner_mem[ctrl.claim_idx] <= claim_elem;
        end
        if (ctrl.query_en)
        begin
            query_owner_reg <= owner_mem[ctrl.query_idx];
            query_owned_reg <= owned_reg[ctrl.query_idx];
        end
    end

    assign walk_point  = walk_point_reg;
    assign query_owner = query_owner_reg;
    assign query_owned = query_owned_reg;

endmodule
`default_nettype wire

// File: hdl/ptb_box_cmp.sv
`default_nettype none
module ptb_box_cmp
(
    input  wire logic             clk,
    input  wire logic             box_load,
    input  wire ptb_pkg::elem_t   load_elem,
    input  wire ptb_pkg::point_t  load_lo,
    input  wire ptb_pkg::point_t  load_hi,
    input  wire ptb_pkg::point_t  point,
    output logic                  hit,
    output ptb_pkg::elem_t        elem
);

    ptb_pkg::point_t lo_reg;
    ptb_pkg::point_t hi_reg;
    ptb_pkg::elem_t  elem_reg;
    logic            in_x;
    logic            in_y;
    logic            in_z;

    always_ff @(posedge clk)
    begin
        if (box_load)
        begin
            lo_reg   <= load_lo;
            hi_reg   <= load_hi;
            elem_reg <= load_elem;
        end
    end

    // signed compares, bounds inclusive
    assign in_x = (lo_reg.x <= point.x) && (point.x <= hi_reg.x);
    assign in_y = (lo_reg.y <= point.y) && (point.y <= hi_reg.y);
    assign in_z = (lo_reg.z <= point.z) && (point.z <= hi_reg.z);

    assign hit  = in_x && in_y && in_z;
    assign elem = elem_reg;

endmodule
`default_nettype wire

// File: hdl/ptb_seq.sv
`default_nettype none
module ptb_seq
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [ptb_pkg::CMD_BITS-1:0] command,
    input  wire ptb_pkg::slot_t           point_index,
    input  wire logic                     cfg_wr_en,
    input  wire ptb_pkg::count_t          cfg_wr_data,
    input  wire logic                     hit,
    input  wire ptb_pkg::elem_t           query_owner,
    input  wire logic                     query_owned,
    output ptb_pkg::store_ctrl_t          ctrl,
    output logic                          box_load,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output ptb_pkg::slot_t                asked_point,
    output ptb_pkg::elem_t                owner_element,
    output logic                          found
);

    ptb_pkg::state_t state_reg;
    ptb_pkg::state_t state_next;
    ptb_pkg::count_t count_reg;
    ptb_pkg::count_t count_next;
    ptb_pkg::slot_t  walk_idx_reg;
    ptb_pkg::slot_t  walk_idx_next;
    ptb_pkg::slot_t  last_idx_reg;
    ptb_pkg::slot_t  last_idx_next;
    logic            cmp_valid_reg;
    logic            cmp_valid_next;
    ptb_pkg::slot_t  cmp_idx_reg;
    ptb_pkg::slot_t  cmp_idx_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    ptb_pkg::slot_t  asked_reg;
    ptb_pkg::slot_t  out_asked_reg;
    ptb_pkg::elem_t  out_owner_reg;
    logic            out_found_reg;

    ptb_pkg::count_t walk_len;
    logic            walk_empty;
    logic            out_load;
    ptb_pkg::cmd_t   cmd;

    assign cmd        = ptb_pkg::cmd_t'(command);
    assign walk_len   = (count_reg > ptb_pkg::COUNT_BITS'(ptb_pkg::MAX_POINTS))
                        ? ptb_pkg::COUNT_BITS'(ptb_pkg::MAX_POINTS) : count_reg;
    assign walk_empty = (walk_len == '0);
    assign out_load   = (state_reg == ptb_pkg::ST_READ) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == ptb_pkg::CMD_TEST && !walk_empty)
                    begin
                        state_next = ptb_pkg::ST_WALK;
                    end
                    else if (cmd == ptb_pkg::CMD_READ)
                    begin
                        state_next = ptb_pkg::ST_READ;
                    end
                end
            end
            ptb_pkg::ST_WALK:
            begin
                if (walk_idx_reg == last_idx_reg)
                begin
                    state_next = ptb_pkg::ST_DRAIN;
                end
            end
            ptb_pkg::ST_DRAIN:
            begin
                state_next = ptb_pkg::ST_IDLE;
            end
            ptb_pkg::ST_READ:
            begin
                if (out_load)
                begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_stall       = 1'b1;
        box_load       = 1'b0;
        ctrl           = '0;
        ctrl.load_idx  = point_index;
        ctrl.query_idx = point_index;
        ctrl.walk_idx  = walk_idx_reg;
        ctrl.claim_idx = cmp_idx_reg;
        ctrl.claim_en  = cmp_valid_reg && hit;
        unique case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (cmd)
                        ptb_pkg::CMD_LOAD: ctrl.load_en  = 1'b1;
                        ptb_pkg::CMD_TEST: box_load      = 1'b1;
                        ptb_pkg::CMD_READ: ctrl.query_en = 1'b1;
                        default:           ctrl.load_en  = 1'b0;
                    endcase
                end
            end
            ptb_pkg::ST_WALK,
            ptb_pkg::ST_DRAIN,
            ptb_pkg::ST_READ:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        count_next     = cfg_wr_en ? cfg_wr_data : count_reg;
        walk_idx_next  = walk_idx_reg;
        last_idx_next  = last_idx_reg;
        if (box_load)
        begin
            walk_idx_next = '0;
            last_idx_next = ptb_pkg::SLOT_BITS'(walk_len - 1'b1);
        end
        else if (state_reg == ptb_pkg::ST_WALK)
        begin
            walk_idx_next = ptb_pkg::SLOT_BITS'(walk_idx_reg + 1'b1);
        end
        // stored point data arrives in the cycle after its walk address
        cmp_valid_next = (state_reg == ptb_pkg::ST_WALK);
        cmp_idx_next   = walk_idx_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptb_pkg::ST_IDLE;
            count_reg     <= '0;
            walk_idx_reg  <= '0;
            last_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            walk_idx_reg  <= walk_idx_next;
            last_idx_reg  <= last_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.query_en)
        begin
            asked_reg <= point_index;
        end
        if (out_load)
        begin
            out_asked_reg <= asked_reg;
            out_owner_reg <= query_owned ? query_owner : '0;
            out_found_reg <= query_owned;
        end
    end

    assign out_valid     = out_valid_reg;
    assign asked_point   = out_asked_reg;
    assign owner_element = out_owner_reg;
    assign found         = out_found_reg;

endmodule
`default_nettype wire

// File: hdl/point_to_box_locator_core.sv
// Point to box locator. A load item (command 0) stores one point and clears its
// owner. A test item (command 1) walks points 0 .. min(point_count,64)-1 through
// one set of six signed comparators, one point per cycle fed from the point
// memory read port, so it keeps the input stalled while it walks and drains (not
// at all when the count is zero); every unowned point inside the box, bounds
// inclusive, takes the element index. A read item (command 2) passes through the
// owner memory read and the read state, staying there while an earlier result
// still waits stalled, and returns one result item with the owner and a found flag;
// further items are taken while that result still waits. point_count must be
// written through cfg_wr_en / cfg_wr_data only while the block is idle; the block does not enforce this.
`default_nettype none
module point_to_box_locator_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ptb_pkg::COUNT_BITS-1:0]    cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ptb_pkg::CMD_BITS-1:0]      command,
    input  wire logic [ptb_pkg::SLOT_BITS-1:0]     point_index,
    input  wire logic [ptb_pkg::ELEMENT_BITS-1:0]  element_index,
    input  wire logic signed [ptb_pkg::COORD_BITS-1:0] coord_x,
    input  wire logic signed [ptb_pkg::COORD_BITS-1:0] coord_y,
    input  wire logic signed [ptb_pkg::COORD_BITS-1:0] coord_z,
    input  wire logic signed [ptb_pkg::COORD_BITS-1:0] box_max_x,
    input  wire logic signed [ptb_pkg::COORD_BITS-1:0] box_max_y,
    input  wire logic signed [ptb_pkg::COORD_BITS-1:0] box_max_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ptb_pkg::SLOT_BITS-1:0]          asked_point,
    output logic [ptb_pkg::ELEMENT_BITS-1:0]       owner_element,
    output logic                                   found
);

    ptb_pkg::store_ctrl_t ctrl;
    ptb_pkg::point_t      in_lo;
    ptb_pkg::point_t      in_hi;
    ptb_pkg::point_t      walk_point;
    ptb_pkg::elem_t       query_owner;
    ptb_pkg::elem_t       box_elem;
    logic                 query_owned;
    logic                 box_load;
    logic                 hit;

    // on a load the min corner fields carry the point itself
    assign in_lo = '{x: coord_x, y: coord_y, z: coord_z};
    assign in_hi = '{x: box_max_x, y: box_max_y, z: box_max_z};

    ptb_seq u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .point_index   (point_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .hit           (hit),
        .query_owner   (query_owner),
        .query_owned   (query_owned),
        .ctrl          (ctrl),
        .box_load      (box_load),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .asked_point   (asked_point),
        .owner_element (owner_element),
        .found         (found)
    );

    ptb_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .load_point  (in_lo),
        .claim_elem  (box_elem),
        .walk_point  (walk_point),
        .query_owner (query_owner),
        .query_owned (query_owned)
    );

    ptb_box_cmp u_cmp
    (
        .clk       (clk),
        .box_load  (box_load),
        .load_elem (element_index),
        .load_lo   (in_lo),
        .load_hi   (in_hi),
        .point     (walk_point),
        .hit       (hit),
        .elem      (box_elem)
    );

endmodule
`default_nettype wire

// File: hdl/ptb_checker.sv
`default_nettype none
module ptb_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [ptb_pkg::CMD_BITS-1:0]      command,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [ptb_pkg::SLOT_BITS-1:0]     asked_point,
    input  wire logic [ptb_pkg::ELEMENT_BITS-1:0]  owner_element,
    input  wire logic                              found
);

    logic in_accept;

    assign in_accept = in_valid && !in_stall;

    // a result waiting on a stall holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(asked_point)
            && $stable(owner_element) && $stable(found))
        else $error("result changed while stalled");

    a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> owner_element == '0)
        else $error("unowned point reported an owner");

    // a load item leaves the block ready for the next item
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && command == ptb_pkg::CMD_LOAD |=> !in_stall)
        else $error("stall after a load item");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && command == ptb_pkg::CMD_READ |=> in_stall)
        else $error("read item did not occupy the block");

    // a new result only ever follows a read item, by way of the read state and the result register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_accept && command == ptb_pkg::CMD_READ, 2))
        else $error("result without a read item");

endmodule

bind point_to_box_locator_core ptb_checker u_ptb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .asked_point   (asked_point),
    .owner_element (owner_element),
    .found         (found)
);
`default_nettype wire

// File: tb/tb_point_to_box_locator_core.sv
`default_nettype none
module tb_point_to_box_locator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_ONE = 256;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 115;
    localparam int PAUSE_AT = 60;
    localparam int NUM_PHASES = 10;

    typedef struct {
        logic [CMD_BITS-1:0] command;
        slot_t               slot;
        elem_t               elem;
        coord_t              lo_x;
        coord_t              lo_y;
        coord_t              lo_z;
        coord_t              hi_x;
        coord_t              hi_y;
        coord_t              hi_z;
    } locator_item_t;

    typedef struct {
        slot_t slot;
        elem_t owner;
        logic  found;
    } owner_reply_t;

    class point_owner_board;
        coord_t       px [MAX_POINTS];
        coord_t       py [MAX_POINTS];
        coord_t       pz [MAX_POINTS];
        elem_t        owner [MAX_POINTS];
        bit           owned [MAX_POINTS];
        bit           loaded [MAX_POINTS];
        count_t       walk_count;
        owner_reply_t owner_replies [$];
        int           mismatch_count;

        function new();
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                owned[i] = 0;
                loaded[i] = 0;
            end
            walk_count = '0;
            mismatch_count = 0;
        endfunction

        function void note_item(locator_item_t it);
            owner_reply_t r;
            int n;
            case (it.command)
                CMD_LOAD:
                begin
                    px[it.slot] = it.lo_x;
                    py[it.slot] = it.lo_y;
                    pz[it.slot] = it.lo_z;
                    owner[it.slot] = '0;
                    owned[it.slot] = 0;
                    loaded[it.slot] = 1;
                end
                CMD_TEST:
                begin
                    n = (walk_count > MAX_POINTS) ? MAX_POINTS : int'(walk_count);
                    // first box that contains a point keeps it
                    for (int i = 0; i < n; i++)
                    begin
                        if (!owned[i] &&
                            it.lo_x <= px[i] && px[i] <= it.hi_x &&
                            it.lo_y <= py[i] && py[i] <= it.hi_y &&
                            it.lo_z <= pz[i] && pz[i] <= it.hi_z)
                        begin
                            owner[i] = it.elem;
                            owned[i] = 1;
                        end
                    end
                end
                CMD_READ:
                begin
                    r.slot = it.slot;
                    r.found = owned[it.slot];
                    r.owner = owned[it.slot] ? owner[it.slot] : '0;
                    owner_replies = {owner_replies, r};
                end
                default: ;
            endcase
        endfunction

        function void check_reply(slot_t got_slot, elem_t got_owner, logic got_found);
            owner_reply_t r;
            if (owner_replies.size() == 0)
            begin
                $error("unexpected result item: asked_point %0d owner_element %0d found %0b",
                       got_slot, got_owner, got_found);
                mismatch_count++;
            end
            else
            begin
                r = owner_replies.pop_front();
                if (got_slot !== r.slot)
                begin
                    $error("asked_point: expected %0d, got %0d", r.slot, got_slot);
                    mismatch_count++;
                end
                if (got_owner !== r.owner)
                begin
                    $error("owner_element: expected %0d, got %0d", r.owner, got_owner);
                    mismatch_count++;
                end
                if (got_found !== r.found)
                begin
                    $error("found: expected %0b, got %0b", r.found, got_found);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    count_t              cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_BITS-1:0] command;
    slot_t               point_index;
    elem_t               element_index;
    coord_t              coord_x;
    coord_t              coord_y;
    coord_t              coord_z;
    coord_t              box_max_x;
    coord_t              box_max_y;
    coord_t              box_max_z;
    logic                out_valid;
    logic                out_stall;
    slot_t               asked_point;
    elem_t               owner_element;
    logic                found;

    point_owner_board sb;
    bit no_idle = 0;
    bit hold_req = 0;
    count_t phase_counts [NUM_PHASES] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd12,
                                          7'd65, 7'd33, 7'd64, 7'd3, 7'd100};

    point_to_box_locator_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .point_index   (point_index),
        .element_index (element_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .box_max_x     (box_max_x),
        .box_max_y     (box_max_y),
        .box_max_z     (box_max_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .asked_point   (asked_point),
        .owner_element (owner_element),
        .found         (found)
    );

    always #4 clk = ~clk;

    function automatic locator_item_t mk(logic [CMD_BITS-1:0] c, slot_t s, elem_t e,
                                         coord_t lx, coord_t ly, coord_t lz,
                                         coord_t hx, coord_t hy, coord_t hz);
        locator_item_t it;
        it.command = c;
        it.slot = s;
        it.elem = e;
        it.lo_x = lx;
        it.lo_y = ly;
        it.lo_z = lz;
        it.hi_x = hx;
        it.hi_y = hy;
        it.hi_z = hz;
        return it;
    endfunction

    // mostly a small lattice so boxes catch points, sometimes the extremes or noise
    function automatic coord_t grid_coord();
        coord_t c;
        case ($urandom_range(0, 19))
            0: c = COORD_MIN;
            1: c = COORD_MAX;
            2: c = coord_t'($urandom);
            default: c = coord_t'((int'($urandom_range(0, 8)) - 4) * 256);
        endcase
        return c;
    endfunction

    function automatic locator_item_t make_random_item();
        locator_item_t it;
        slot_t loaded_q [$];
        coord_t lo [3];
        coord_t hi [3];
        int walk_n;
        int hole;
        int pick;
        int kind;
        int a;
        int i;
        walk_n = (sb.walk_count > MAX_POINTS) ? MAX_POINTS : int'(sb.walk_count);
        hole = -1;
        for (i = walk_n - 1; i >= 0; i--)
            if (!sb.loaded[i])
                hole = i;
        for (i = 0; i < MAX_POINTS; i++)
            if (sb.loaded[i])
                loaded_q = {loaded_q, slot_t'(i)};
        it = mk(CMD_UNUSED, slot_t'($urandom), elem_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            it.command = CMD_UNUSED;
        end
        else if (pick < 40 || (pick < 75 && hole >= 0) ||
                 (pick >= 75 && loaded_q.size() == 0))
        begin
            // a box test may only walk slots that hold a point
            it.command = CMD_LOAD;
            if (hole >= 0)
                it.slot = slot_t'(hole);
            else if (walk_n > 0 && $urandom_range(0, 3) != 0)
                it.slot = slot_t'($urandom_range(0, walk_n - 1));
            it.lo_x = grid_coord();
            it.lo_y = grid_coord();
            it.lo_z = grid_coord();
        end
        else if (pick < 75)
        begin
            it.command = CMD_TEST;
            case ($urandom_range(0, 7))
                0: it.elem = '0;
                1: it.elem = '1;
                default: ;
            endcase
            for (i = 0; i < 3; i++)
            begin
                lo[i] = coord_t'((int'($urandom_range(0, 8)) - 5) * 256);
                hi[i] = lo[i] + coord_t'(int'($urandom_range(0, 4)) * 256);
            end
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                for (i = 0; i < 3; i++)
                begin
                    lo[i] = COORD_MIN;
                    hi[i] = COORD_MAX;
                end
            end
            else if (kind == 1)
            begin
                // min above max on one axis
                a = $urandom_range(0, 2);
                hi[a] = lo[a] - COORD_ONE;
            end
            else if (kind == 2)
            begin
                for (i = 0; i < 3; i++)
                begin
                    lo[i] = coord_t'($urandom);
                    hi[i] = coord_t'($urandom);
                end
            end
            it.lo_x = lo[0];
            it.lo_y = lo[1];
            it.lo_z = lo[2];
            it.hi_x = hi[0];
            it.hi_y = hi[1];
            it.hi_z = hi[2];
        end
        else
        begin
            it.command = CMD_READ;
            it.slot = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        end
        return it;
    endfunction

    task automatic send_item(locator_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= it.command;
        point_index   <= it.slot;
        element_index <= it.elem;
        coord_x       <= it.lo_x;
        coord_y       <= it.lo_y;
        coord_z       <= it.lo_z;
        box_max_x     <= it.hi_x;
        box_max_y     <= it.hi_y;
        box_max_z     <= it.hi_z;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(it);
    endtask

    task automatic wait_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owner_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_point_count(count_t value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.walk_count = value;
    endtask

    initial
    begin
        locator_item_t it;
        int counted;
        sb = new();
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_valid      <= 1'b0;
        out_stall     <= 1'b0;
        command       <= CMD_LOAD;
        point_index   <= '0;
        element_index <= '0;
        coord_x       <= '0;
        coord_y       <= '0;
        coord_z       <= '0;
        box_max_x     <= '0;
        box_max_y     <= '0;
        box_max_z     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_point_count(7'd4);
        send_item(mk(CMD_LOAD, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
        send_item(mk(CMD_LOAD, 1, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
        send_item(mk(CMD_LOAD, 2, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_LOAD, 3, 0, -COORD_ONE, 2 * COORD_ONE, COORD_MAX, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        // empty on x, full on y and z
        send_item(mk(CMD_TEST, 0, 16'd5, COORD_ONE, COORD_MIN, COORD_MIN,
                     -COORD_ONE, COORD_MAX, COORD_MAX));
        send_item(mk(CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0));
        // degenerate box, the bounds themselves count as inside
        send_item(mk(CMD_TEST, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_TEST, 0, 16'd7, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MAX, COORD_MAX, COORD_MAX));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 3, 0, 0, 0, 0, 0, 0, 0));
        // reloading a slot clears its owner
        send_item(mk(CMD_LOAD, 1, 0, COORD_ONE, COORD_ONE, COORD_ONE, 0, 0, 0));
        send_item(mk(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_TEST, 0, 16'd0, COORD_ONE, COORD_ONE, COORD_ONE,
                     COORD_ONE, COORD_ONE, COORD_ONE));
        send_item(mk(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_UNUSED, 5, 16'h1234, COORD_MAX, 0, COORD_MIN, 0, 0, 0));
        send_item(mk(CMD_LOAD, 63, 0, COORD_MAX, COORD_MIN, -COORD_ONE, 0, 0, 0));
        send_item(mk(CMD_READ, 63, 0, 0, 0, 0, 0, 0, 0));
        wait_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_point_count(phase_counts[p]);
            no_idle = (p == 4);
            if (p == 1)
                hold_req = 1;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = make_random_item();
                send_item(it);
                if (it.command != CMD_UNUSED)
                    counted++;
                if (counted == PAUSE_AT && it.command != CMD_UNUSED)
                    wait_replies();
            end
            wait_replies();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (sb.mismatch_count == 0)
            $display("tb_point_to_box_locator_core: PASS");
        else
            $display("tb_point_to_box_locator_core: FAIL");
        $finish;
    end

    // result side: random stall per item, one long hold-off on request
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            n = no_idle ? 0 : $urandom_range(0, 7);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_reply(asked_point, owner_element, found);
        end
    end

    initial
    begin
        #4_000_000;
        $display("tb_point_to_box_locator_core: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
hdl/ptb_pkg.sv
hdl/ptb_store.sv
hdl/ptb_box_cmp.sv
hdl/ptb_seq.sv
hdl/point_to_box_locator_core.sv
hdl/ptb_checker.sv
tb/tb_point_to_box_locator_core.sv
